// File: design/pltic_pkg.sv
// ----------------------------------------------------------------------------
// pltic_pkg
// shared types and constants for the piecewise linear table interpolator
// ----------------------------------------------------------------------------
package pltic_pkg;

  localparam int DEFAULT_TABLE_DEPTH = 16;
  localparam int QUEUE_DEPTH = 2;

  typedef enum logic {
    CMD_LOAD  = 1'b0,
    CMD_QUERY = 1'b1
  } command_t;

  typedef enum logic [1:0] {
    REGION_INTERIOR = 2'd0,
    REGION_BELOW    = 2'd1,
    REGION_ABOVE    = 2'd2,
    REGION_EMPTY    = 2'd3
  } region_t;

  typedef enum logic {
    REG_ENTRY_COUNT    = 1'b0,
    REG_FALLBACK_VALUE = 1'b1
  } reg_index_t;

  typedef enum logic [1:0] {
    ST_IDLE   = 2'd0,
    ST_SEARCH = 2'd1,
    ST_DIVIDE = 2'd2,
    ST_DONE   = 2'd3
  } back_state_t;

  // query as queued between front and back
  typedef struct packed {
    logic [15:0] query;
  } job_t;

endpackage

// File: design/pltic_front.sv
// ----------------------------------------------------------------------------
// pltic_front
// accepts items, performs table loads, queues queries for the back end
// ----------------------------------------------------------------------------
module pltic_front import pltic_pkg::*; #(
  parameter int TABLE_DEPTH = DEFAULT_TABLE_DEPTH,
  localparam int IW = (TABLE_DEPTH > 1) ? $clog2(TABLE_DEPTH) : 1
) (
  input  logic        clk,
  input  logic        rst,
  input  logic        in_valid,
  output logic        in_ready,
  input  logic        in_command,
  input  logic [3:0]  in_index,
  input  logic [15:0] in_position,
  input  logic [15:0] in_value,
  input  logic [15:0] in_query,
  input  logic        back_idle,
  output logic        load_we,
  output logic [IW-1:0] load_addr,
  output logic [15:0] load_position,
  output logic [15:0] load_value,
  output logic        job_valid,
  input  logic        job_ready,
  output job_t        job
);

  localparam int CW = $clog2(QUEUE_DEPTH + 1);
  localparam int PW = (QUEUE_DEPTH > 1) ? $clog2(QUEUE_DEPTH) : 1;

  job_t          queue [QUEUE_DEPTH];
  logic [PW-1:0] wr_ptr;
  logic [PW-1:0] rd_ptr;
  logic [CW-1:0] fill;
  logic          push;
  logic          pop;
  logic          in_range;

  // load index range check against depth
  assign in_range = ({28'd0, in_index} < 32'(TABLE_DEPTH));
  // a load waits until every earlier query has left the queue and the back end
  assign in_ready = (in_command == CMD_QUERY) ? (fill != CW'(QUEUE_DEPTH)) :
                                                ((fill == '0) && back_idle);
  assign push     = in_valid && in_ready && (in_command == CMD_QUERY);
  assign pop      = job_valid && job_ready;

  assign load_we       = in_valid && in_ready && (in_command == CMD_LOAD) && in_range;
  assign load_addr     = IW'(in_index);
  assign load_position = in_position;
  assign load_value    = in_value;

  assign job_valid = (fill != '0);
  assign job       = queue[rd_ptr];

  // query queue
  always_ff @(posedge clk) begin
    if (push) begin
      queue[wr_ptr].query <= in_query;
    end
    if (rst) begin
      wr_ptr <= '0;
      rd_ptr <= '0;
      fill   <= '0;
    end else begin
      if (push) begin
        wr_ptr <= (wr_ptr == PW'(QUEUE_DEPTH - 1)) ? '0 : wr_ptr + 1'b1;
      end
      if (pop) begin
        rd_ptr <= (rd_ptr == PW'(QUEUE_DEPTH - 1)) ? '0 : rd_ptr + 1'b1;
      end
      fill <= fill + CW'(push) - CW'(pop);
    end
  end

endmodule

// File: design/pltic_back.sv
// ----------------------------------------------------------------------------
// pltic_back
// holds the table, searches breakpoints and divides serially
// ----------------------------------------------------------------------------
module pltic_back import pltic_pkg::*; #(
  parameter int TABLE_DEPTH = DEFAULT_TABLE_DEPTH,
  localparam int IW = (TABLE_DEPTH > 1) ? $clog2(TABLE_DEPTH) : 1
) (
  input  logic          clk,
  input  logic          rst,
  input  logic          load_we,
  input  logic [IW-1:0] load_addr,
  input  logic [15:0]   load_position,
  input  logic [15:0]   load_value,
  input  logic [4:0]    entry_count,
  input  logic [15:0]   fallback_value,
  input  logic          job_valid,
  output logic          job_ready,
  input  job_t          job,
  output logic          idle,
  output logic          out_valid,
  input  logic          out_ready,
  output logic [15:0]   out_result,
  output logic [1:0]    out_region
);

  localparam int NW = $clog2(TABLE_DEPTH + 1);

  logic [15:0] pos_mem [TABLE_DEPTH];
  logic [15:0] val_mem [TABLE_DEPTH];

  back_state_t state, state_next;
  logic [NW-1:0] n;
  logic [IW-1:0] idx;
  logic [IW-1:0] last;
  logic [15:0]   q;
  logic [15:0]   x_prev;
  logic [15:0]   y_prev;
  logic [15:0]   rd_pos;
  logic [15:0]   rd_val;
  logic [15:0]   last_pos;
  logic [15:0]   last_val;
  logic [15:0]   rem_x;
  logic [15:0]   den;
  logic          neg;
  logic [32:0]   quot;
  logic [33:0]   rem;
  logic [5:0]    bit_cnt;
  logic          first;
  logic [15:0]   res;
  logic [1:0]    reg_out;
  logic [33:0]   rem_sh;
  logic [33:0]   rem_sub;
  logic [16:0]   dy;
  logic [16:0]   dy_abs;
  logic [32:0]   prod;
  logic [32:0]   qv;

  // saturate entry count to the depth
  always_comb begin
    if ({27'd0, entry_count} > 32'(TABLE_DEPTH)) begin
      n = NW'(TABLE_DEPTH);
    end else begin
      n = NW'(entry_count);
    end
  end

  // table write port
  always_ff @(posedge clk) begin
    if (load_we) begin
      pos_mem[load_addr] <= load_position;
      val_mem[load_addr] <= load_value;
    end
  end

  assign rd_pos   = pos_mem[idx];
  assign rd_val   = val_mem[idx];
  // last breakpoint, checked at each scan step before the interior test
  assign last_pos = pos_mem[last];
  assign last_val = val_mem[last];

  // divider step and product setup
  assign rem_sh  = {rem[32:0], quot[32]};
  assign rem_sub = rem_sh - {18'd0, den};
  assign dy      = {rd_val[15], rd_val} - {y_prev[15], y_prev};
  assign dy_abs  = dy[16] ? (~dy + 17'd1) : dy;
  assign prod    = dy_abs[16:0] * {1'b0, q - x_prev};
  assign qv      = neg ? (~quot + 33'd1) : quot;

  assign job_ready = (state == ST_IDLE) && !out_valid;
  assign idle      = (state == ST_IDLE);

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= ST_IDLE;
    end else begin
      state <= state_next;
    end
  end

  always_comb begin
    state_next = state;
    unique case (state)
      ST_IDLE:   if (job_valid && job_ready) state_next = ST_SEARCH;
      ST_SEARCH: begin
        if (!first && (n == '0 || q <= x_prev || q >= last_pos)) begin
          state_next = ST_DONE;
        end else if (!first && q <= rd_pos) begin
          state_next = ST_DIVIDE;
        end
      end
      ST_DIVIDE: if (bit_cnt == 6'd33) state_next = ST_DONE;
      ST_DONE:   state_next = ST_IDLE;
      default:   state_next = ST_IDLE;
    endcase
  end

  // datapath
  always_ff @(posedge clk) begin
    unique case (state)
      ST_IDLE: begin
        q     <= job.query;
        idx   <= '0;
        first <= 1'b1;
        last  <= (n == '0) ? '0 : IW'(n - 1'b1);
      end
      ST_SEARCH: begin
        if (first) begin
          first   <= 1'b0;
          x_prev  <= rd_pos;
          y_prev  <= rd_val;
          res     <= (n == '0) ? fallback_value : rd_val;
          reg_out <= (n == '0) ? REGION_EMPTY : REGION_BELOW;
          if (n != '0 && q > rd_pos && idx != last) begin
            idx <= idx + 1'b1;
          end
          if (n == NW'(1) && q > rd_pos) begin
            reg_out <= REGION_ABOVE;
          end
        end else if (n == '0 || q <= x_prev) begin
          // result already set
        end else if (q >= last_pos) begin
          res     <= last_val;
          reg_out <= REGION_ABOVE;
        end else if (q <= rd_pos) begin
          den      <= rd_pos - x_prev;
          neg      <= dy[16];
          quot     <= prod;
          rem      <= '0;
          bit_cnt  <= '0;
          reg_out  <= REGION_INTERIOR;
          rem_x    <= rd_val;
        end else begin
          x_prev <= rd_pos;
          y_prev <= rd_val;
          idx    <= idx + 1'b1;
        end
      end
      ST_DIVIDE: begin
        if (bit_cnt == 6'd33) begin
          res <= (rd_pos == x_prev) ? rem_x : y_prev + qv[15:0];
        end else begin
          bit_cnt <= bit_cnt + 1'b1;
          if (!rem_sub[33]) begin
            rem  <= rem_sub;
            quot <= {quot[31:0], 1'b1};
          end else begin
            rem  <= rem_sh;
            quot <= {quot[31:0], 1'b0};
          end
        end
      end
      default: ;
    endcase
  end

  // output register
  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (state == ST_DONE) begin
      out_valid  <= 1'b1;
      out_result <= res;
      out_region <= reg_out;
    end else if (out_ready) begin
      out_valid <= 1'b0;
    end
  end

endmodule

// File: design/piecewise_linear_table_interp_core.sv
// sequence: a query taken by the back end goes through the breakpoint search and,
// when interior, the serial divider, then the done state and the output register
// throughput: one query in the back end at a time, held until its result is taken;
// a load waits for the queue and back end to drain, then writes the table
// reset: sync active high clears control state and configuration registers; table undefined
// ----------------------------------------------------------------------------
// piecewise_linear_table_interp_core
// calibration table interpolator top level
// ----------------------------------------------------------------------------
module piecewise_linear_table_interp_core import pltic_pkg::*; #(
  parameter int TABLE_DEPTH = DEFAULT_TABLE_DEPTH
) (
  input  logic        clk,
  input  logic        rst,
  input  logic        s_tvalid,
  output logic        s_tready,
  input  logic [55:0] s_tdata,   // entry_index, point_position, point_value, query_position
  input  logic        s_tuser,   // command
  output logic        m_tvalid,
  input  logic        m_tready,
  output logic [15:0] m_tdata,   // result_value
  output logic [1:0]  m_tuser,   // region
  input  logic        cfg_valid,
  output logic        cfg_ready,
  input  logic [0:0]  cfg_index,
  input  logic [15:0] cfg_data
);

  localparam int IW = (TABLE_DEPTH > 1) ? $clog2(TABLE_DEPTH) : 1;

  logic [4:0]    entry_count;
  logic [15:0]   fallback_value;
  logic          load_we;
  logic [IW-1:0] load_addr;
  logic [15:0]   load_position;
  logic [15:0]   load_value;
  logic          job_valid;
  logic          job_ready;
  job_t          job;
  logic          back_idle;

  assign cfg_ready = 1'b1;

  // configuration registers
  always_ff @(posedge clk) begin
    if (rst) begin
      entry_count    <= '0;
      fallback_value <= '0;
    end else if (cfg_valid) begin
      unique case (cfg_index)
        REG_ENTRY_COUNT:    entry_count    <= cfg_data[4:0];
        REG_FALLBACK_VALUE: fallback_value <= cfg_data;
        default: ;
      endcase
    end
  end

  pltic_front #(.TABLE_DEPTH(TABLE_DEPTH)) u_front (
    .clk, .rst,
    .in_valid(s_tvalid), .in_ready(s_tready), .in_command(s_tuser),
    .in_index(s_tdata[3:0]), .in_position(s_tdata[19:4]),
    .in_value(s_tdata[35:20]), .in_query(s_tdata[51:36]),
    .back_idle,
    .load_we, .load_addr, .load_position, .load_value,
    .job_valid, .job_ready, .job
  );

  pltic_back #(.TABLE_DEPTH(TABLE_DEPTH)) u_back (
    .clk, .rst,
    .load_we, .load_addr, .load_position, .load_value,
    .entry_count, .fallback_value,
    .job_valid, .job_ready, .job,
    .idle(back_idle),
    .out_valid(m_tvalid), .out_ready(m_tready),
    .out_result(m_tdata), .out_region(m_tuser)
  );

  // a result with an entry count of zero must report the empty region
  a_empty_region: assert property (@(posedge clk) disable iff (rst)
    $rose(m_tvalid) && entry_count == 5'd0 |-> m_tuser == REGION_EMPTY)
    else $error("empty table must report fallback region");

  a_no_load_on_full: assert property (@(posedge clk) disable iff (rst)
    !s_tready |-> !load_we)
    else $error("load while front stalled");

  a_fallback_value: assert property (@(posedge clk) disable iff (rst)
    $rose(m_tvalid) && m_tuser == REGION_EMPTY |-> m_tdata == fallback_value)
    else $error("fallback value mismatch");

endmodule
